[rtl/yin_pitch_detector_unit_defines.svh]
// Assertion macros shared by the checker of the pitch detector.
// No dependencies; include once per file that asserts.
`ifndef YIN_PITCH_DETECTOR_UNIT_DEFINES_SVH
`define YIN_PITCH_DETECTOR_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define YPD_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ypd: implication failed");

// Next-cycle implication, disabled in reset.
`define YPD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ypd: next-cycle check failed");

`endif

[rtl/ypd_pkg.sv]
// Package of the pitch detector: request and result types, register codes, constants.
// No dependencies.
package ypd_pkg;

  localparam int SAMPLE_BITS = 16;

  typedef struct packed {
    logic                        command;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [15:0]                 elapsed_ticks;
  } in_t;

  typedef struct packed {
    logic        voiced;
    logic [20:0] period_q;
    logic [16:0] confidence_q;
    logic [43:0] level_energy;
  } out_t;

  typedef enum logic [2:0] {
    REG_LAG_MIN     = 3'd0,
    REG_LAG_MAX     = 3'd1,
    REG_DIP_THRESH  = 3'd2,
    REG_GATE_LEVEL  = 3'd3,
    REG_HOLD_TICKS  = 3'd4,
    REG_PERIOD_LOW  = 3'd5,
    REG_PERIOD_HIGH = 3'd6,
    REG_UNUSED      = 3'd7
  } reg_idx_t;

  localparam logic        CMD_PUSH    = 1'b0;
  localparam logic        CMD_ANALYSE = 1'b1;

  localparam int          NORM_W   = 28;
  localparam logic [27:0] NORM_MAX = 28'hFFFFFFF;
  localparam logic [27:0] ONE_Q16  = 28'd65536;
  localparam logic [16:0] IDLE_MAX = 17'h1FFFF;
  localparam int          QUOT_W   = 30;

endpackage

[rtl/ypd_ram.sv]
// Generic RAM: one write port, two registered read ports.
// No dependencies.
module ypd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  output logic [WIDTH-1:0]         rdata_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_b
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule

[rtl/yin_pitch_detector_unit.sv]
// YIN pitch detector top level: sample history, difference pass, shared divider, dip search.
// Depends on ypd_pkg and ypd_ram.
//
// Usage:
//   Request channel: start/busy with in_data. A request is taken at a clock edge where start
//   is high and busy is low. A push request (command 0) writes one sample into the history
//   ring in that cycle; busy stays low, so pushes may arrive every cycle while idle.
//   An analyse request (command 1) raises busy until its single result has been issued.
//   Result channel: out_valid pulses for exactly one cycle with out_data; the receiver has to
//   take it then, there is no back-pressure. Pushes produce no result.
//   Configuration: APB-style port, register i at byte address 4*i, pready tied high.
//   Write registers only while busy is low.
// Sequence of an analyse (L = effective longest lag):
//   energy pass, gate check, then per lag tau a difference pass, running sum and split
//   multiply, a normalising division and a search step; the search stops at the lag
//   after the dip bottom or at L. Refinement then runs a parabolic fit on the divider.
//   Analyse time is set by the one squarer fed from the two read ports of the sample
//   memory (one term per cycle) and by the shared radix-2 divider that serves both
//   normalisation and the parabolic fit.
// Reset: synchronous, active low. Reset clears the write pointer, the held period and
//   confidence, and the idle count; history entries never written read as zero through a
//   fill marker, so no clearing pass is needed and the block is ready right after reset.
module yin_pitch_detector_unit #(
  parameter int MAX_LAG     = 4096,
  parameter int RING_DEPTH  = 16384
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  ypd_pkg::in_t  in_data,
  output logic          out_valid,
  output ypd_pkg::out_t out_data,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [4:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);
  import ypd_pkg::*;

  localparam int RAW   = $clog2(RING_DEPTH);
  localparam int LCAP  = (MAX_LAG < RING_DEPTH / 3) ? MAX_LAG : RING_DEPTH / 3;
  localparam int LW    = $clog2(LCAP + 1);
  localparam int IW    = LW + 1;
  localparam int SW    = SAMPLE_BITS;
  localparam int DIFW  = SW + 1;
  localparam int SQW   = 2 * SW + 1;
  localparam int DW    = SQW + $clog2(2 * LCAP);
  localparam int RUNW  = DW + LW;
  localparam int DVW   = (RUNW > 32) ? RUNW : 32;
  localparam int NUMW  = (RUNW + 16 > 40) ? RUNW + 16 : 40;
  localparam int SHW   = DVW + QUOT_W;
  localparam int HALF  = (DW + 1) / 2;
  localparam int PERW  = LW + 10;
  localparam int GW    = 31 + IW;
  localparam int ECW   = (DW > GW) ? DW : GW;
  localparam int QCW   = $clog2(QUOT_W);

  typedef enum logic [3:0] {
    S_IDLE, S_PASS, S_GMUL, S_GCMP, S_ACC, S_MLO, S_MHI,
    S_NORM, S_DIV, S_SRCH, S_REF, S_CHK, S_FIN
  } state_t;

  typedef enum logic [1:0] {SR_SEEK, SR_WALK, SR_DONE} srch_t;

  state_t state_r;
  srch_t  srch_r;

  // configuration
  logic [11:0] lag_min_r;
  logic [12:0] lag_max_r;
  logic [15:0] dip_thr_r;
  logic [30:0] gate_r;
  logic [15:0] hold_r;
  logic [20:0] per_low_r, per_high_r;

  // history ring
  logic [RAW-1:0] wp_r;
  logic           wrapped_r;
  logic [SW-1:0]  rd_a, rd_b;
  logic [RAW-1:0] ra_r, rb_r, rb_start_r, base_r;

  // analyse control
  logic [LW-1:0]  len_r, tau_r, cand_r;
  logic [11:0]    lmin_r;
  logic [IW-1:0]  integ_r, cnt_r;
  logic [15:0]    elapsed_r;
  logic           issue_r, p1_v_r, p1_va_r, p1_vb_r, p2_v_r;
  logic [SQW-1:0] sq_r;
  logic [DW-1:0]  acc_r, d_r, energy_r;
  logic [GW-1:0]  gprod_r;
  logic [RUNW-1:0] run_r, prod_r;

  // divider
  logic [NUMW-1:0]   div_rem_r;
  logic [SHW-1:0]    div_den_r;
  logic [QUOT_W-1:0] div_q_r;
  logic [QCW-1:0]    div_cnt_r;
  logic              div_norm_r, neg_r;

  // search and result
  logic [NORM_W-1:0] norm_r, prev_n_r, nm1_r, n0_r, np1_r;
  logic              has_np1_r, det_r;
  logic [PERW-1:0]   per_r;
  logic [20:0]       held_p_r;
  logic [16:0]       held_c_r;
  logic [16:0]       idle_r;
  logic              out_valid_r;
  out_t              out_r;

  // ---------------------------------------------------------------- request decode
  logic take, push_take, ana_take;
  assign busy      = (state_r != S_IDLE);
  assign take      = start && !busy;
  assign push_take = take && (in_data.command == CMD_PUSH);
  assign ana_take  = take && (in_data.command == CMD_ANALYSE);

  // ---------------------------------------------------------------- window geometry
  logic [LW-1:0]  len_c;
  logic [11:0]    lmin_c;
  logic [LW+1:0]  spn_c;
  logic [RAW+1:0] base_t;
  logic [RAW-1:0] base_c;
  assign len_c  = (15'(lag_max_r) > 15'(LCAP)) ? LW'(LCAP) : LW'(lag_max_r);
  assign lmin_c = (lag_min_r < 12'd2) ? 12'd2 : lag_min_r;
  assign spn_c  = (LW + 2)'({len_c, 1'b0}) + (LW + 2)'(len_c);
  assign base_t = (RAW + 2)'(wp_r) + (RAW + 2)'(RING_DEPTH) - (RAW + 2)'(spn_c);
  assign base_c = (base_t >= (RAW + 2)'(RING_DEPTH)) ? RAW'(base_t - (RAW + 2)'(RING_DEPTH))
                                                     : RAW'(base_t);

  function automatic logic [RAW-1:0] ring_inc(input logic [RAW-1:0] a);
    ring_inc = (a == RAW'(RING_DEPTH - 1)) ? '0 : a + RAW'(1);
  endfunction

  // Entries past the fill point read as zero until the ring has wrapped once.
  logic ok_a, ok_b;
  assign ok_a = wrapped_r || (ra_r < wp_r);
  assign ok_b = wrapped_r || (rb_r < wp_r);

  ypd_ram #(.WIDTH(SW), .DEPTH(RING_DEPTH)) u_ring (
    .clk     (clk),
    .we      (push_take),
    .waddr   (wp_r),
    .wdata   (SW'({{SW{1'b0}}, $unsigned(in_data.sample)})),
    .raddr_a (ra_r),
    .rdata_a (rd_a),
    .raddr_b (rb_r),
    .rdata_b (rd_b)
  );

  // ---------------------------------------------------------------- squarer
  logic signed [DIFW-1:0]   sa_c, sb_c, diff_c;
  logic signed [2*DIFW-1:0] sq_full;
  assign sa_c    = p1_va_r ? {rd_a[SW-1], rd_a} : '0;
  assign sb_c    = p1_vb_r ? {rd_b[SW-1], rd_b} : '0;
  assign diff_c  = sa_c - sb_c;
  assign sq_full = diff_c * diff_c;

  logic pass_done;
  assign pass_done = !issue_r && !p1_v_r && !p2_v_r;

  // ---------------------------------------------------------------- divider step
  logic [SHW-1:0]    rem_ext;
  logic              div_ge;
  logic [QUOT_W-1:0] q_nxt;
  assign rem_ext = SHW'(div_rem_r);
  assign div_ge  = (rem_ext >= div_den_r);
  assign q_nxt   = {div_q_r[QUOT_W-2:0], div_ge};

  logic [8:0]      qq_c;
  assign qq_c = (q_nxt > QUOT_W'(256)) ? 9'd256 : q_nxt[8:0];

  // ---------------------------------------------------------------- refinement terms
  logic signed [30:0] a_c, nd_c;
  logic [30:0]        mag_c;
  logic [PERW-1:0]    base_p;
  assign a_c    = $signed({3'b0, nm1_r}) - $signed({2'b0, n0_r, 1'b0}) + $signed({3'b0, np1_r});
  assign nd_c   = $signed({3'b0, nm1_r}) - $signed({3'b0, np1_r});
  assign mag_c  = nd_c[30] ? 31'(-nd_c) : 31'(nd_c);
  assign base_p = PERW'({cand_r, 8'b0});

  logic walk_end;
  assign walk_end = (srch_r == SR_WALK) && !(norm_r < n0_r);

  // ---------------------------------------------------------------- hold logic
  logic [17:0] idle_sum;
  logic [16:0] idle_nxt;
  logic [20:0] held_p_nxt;
  logic [16:0] held_c_nxt, conf_c;
  assign conf_c   = (n0_r >= ONE_Q16) ? 17'd0 : 17'(ONE_Q16 - n0_r);
  assign idle_sum = 18'(idle_r) + 18'(elapsed_r);
  always_comb begin
    idle_nxt   = idle_sum[17] ? IDLE_MAX : idle_sum[16:0];
    held_p_nxt = held_p_r;
    held_c_nxt = held_c_r;
    if (det_r) begin
      idle_nxt   = '0;
      held_p_nxt = 21'(per_r);
      held_c_nxt = conf_c;
    end else if (idle_nxt > 17'(hold_r)) begin
      held_p_nxt = '0;
      held_c_nxt = '0;
    end
  end

  // ---------------------------------------------------------------- sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      srch_r      <= SR_SEEK;
      wp_r        <= '0;
      wrapped_r   <= 1'b0;
      issue_r     <= 1'b0;
      p1_v_r      <= 1'b0;
      p2_v_r      <= 1'b0;
      held_p_r    <= '0;
      held_c_r    <= '0;
      idle_r      <= '0;
      out_valid_r <= 1'b0;
      lag_min_r   <= 12'd24;
      lag_max_r   <= 13'd1200;
      dip_thr_r   <= 16'd13107;
      gate_r      <= 31'd6768;
      hold_r      <= 16'd700;
      per_low_r   <= 21'd6144;
      per_high_r  <= 21'd307200;
    end else begin
      // strobe the result in the cycle after the final state
      out_valid_r <= (state_r == S_FIN);

      // register writes
      if (psel && penable && pwrite && pready) begin
        unique case (reg_idx_t'(paddr[4:2]))
          REG_LAG_MIN:     lag_min_r  <= pwdata[11:0];
          REG_LAG_MAX:     lag_max_r  <= pwdata[12:0];
          REG_DIP_THRESH:  dip_thr_r  <= pwdata[15:0];
          REG_GATE_LEVEL:  gate_r     <= pwdata[30:0];
          REG_HOLD_TICKS:  hold_r     <= pwdata[15:0];
          REG_PERIOD_LOW:  per_low_r  <= pwdata[20:0];
          REG_PERIOD_HIGH: per_high_r <= pwdata[20:0];
          REG_UNUSED:      ;
        endcase
      end

      // difference pipeline: read, square, accumulate
      p1_v_r  <= issue_r;
      p1_va_r <= issue_r && ok_a;
      p1_vb_r <= issue_r && ok_b && (tau_r != '0);
      p2_v_r  <= p1_v_r;
      if (p1_v_r) begin
        sq_r <= SQW'($unsigned(sq_full));
      end
      if (p2_v_r) begin
        acc_r <= acc_r + DW'(sq_r);
      end
      if (issue_r) begin
        ra_r  <= ring_inc(ra_r);
        rb_r  <= ring_inc(rb_r);
        cnt_r <= cnt_r + IW'(1);
        if (cnt_r == integ_r - IW'(1)) begin
          issue_r <= 1'b0;
        end
      end

      unique case (state_r)
        S_IDLE: begin
          if (push_take) begin
            wp_r <= ring_inc(wp_r);
            if (wp_r == RAW'(RING_DEPTH - 1)) begin
              wrapped_r <= 1'b1;
            end
          end
          if (ana_take) begin
            len_r     <= len_c;
            lmin_r    <= lmin_c;
            integ_r   <= {len_c, 1'b0};
            base_r    <= base_c;
            elapsed_r <= in_data.elapsed_ticks;
            tau_r     <= '0;
            ra_r      <= base_c;
            rb_r      <= base_c;
            acc_r     <= '0;
            cnt_r     <= '0;
            issue_r   <= (len_c != '0);
            state_r   <= S_PASS;
          end
        end
        S_PASS: begin
          if (pass_done) begin
            if (tau_r == '0) begin
              energy_r <= acc_r;
              state_r  <= S_GMUL;
            end else begin
              state_r  <= S_ACC;
            end
          end
        end
        S_GMUL: begin
          gprod_r <= GW'(gate_r) * GW'(integ_r);
          state_r <= S_GCMP;
        end
        S_GCMP: begin
          if (ECW'(energy_r) > ECW'(gprod_r)) begin
            // open lag 1
            tau_r      <= LW'(1);
            rb_start_r <= ring_inc(base_r);
            rb_r       <= ring_inc(base_r);
            ra_r       <= base_r;
            acc_r      <= '0;
            cnt_r      <= '0;
            issue_r    <= 1'b1;
            run_r      <= '0;
            srch_r     <= SR_SEEK;
            has_np1_r  <= 1'b0;
            prev_n_r   <= ONE_Q16;
            state_r    <= S_PASS;
          end else begin
            det_r   <= 1'b0;
            state_r <= S_FIN;
          end
        end
        S_ACC: begin
          d_r     <= acc_r;
          run_r   <= run_r + RUNW'(acc_r);
          state_r <= S_MLO;
        end
        S_MLO: begin
          prod_r  <= RUNW'(RUNW'(d_r[HALF-1:0]) * RUNW'(tau_r));
          state_r <= S_MHI;
        end
        S_MHI: begin
          prod_r  <= prod_r + (RUNW'(RUNW'(d_r[DW-1:HALF]) * RUNW'(tau_r)) << HALF);
          state_r <= S_NORM;
        end
        S_NORM: begin
          if (run_r == '0) begin
            norm_r  <= ONE_Q16;
            state_r <= S_SRCH;
          end else begin
            div_rem_r  <= NUMW'({prod_r, 16'b0});
            div_den_r  <= SHW'(run_r) << (QUOT_W - 1);
            div_q_r    <= '0;
            div_cnt_r  <= '0;
            div_norm_r <= 1'b1;
            state_r    <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_ge) begin
            div_rem_r <= NUMW'(rem_ext - div_den_r);
          end
          div_q_r   <= q_nxt;
          div_den_r <= div_den_r >> 1;
          div_cnt_r <= div_cnt_r + QCW'(1);
          if (div_cnt_r == QCW'(QUOT_W - 1)) begin
            if (div_norm_r) begin
              norm_r  <= (q_nxt > QUOT_W'(NORM_MAX)) ? NORM_MAX : q_nxt[NORM_W-1:0];
              state_r <= S_SRCH;
            end else begin
              per_r   <= neg_r ? base_p - PERW'(qq_c) : base_p + PERW'(qq_c);
              state_r <= S_CHK;
            end
          end
        end
        S_SRCH: begin
          prev_n_r <= norm_r;
          priority case (srch_r)
            SR_SEEK: begin
              if (16'(tau_r) >= 16'(lmin_r) && 16'(norm_r) < dip_thr_r
                  && norm_r < NORM_W'(dip_thr_r)) begin
                cand_r <= tau_r;
                nm1_r  <= prev_n_r;
                n0_r   <= norm_r;
                srch_r <= SR_WALK;
              end
            end
            SR_WALK: begin
              if (walk_end) begin
                np1_r     <= norm_r;
                has_np1_r <= 1'b1;
                srch_r    <= SR_DONE;
              end else begin
                cand_r <= tau_r;
                nm1_r  <= n0_r;
                n0_r   <= norm_r;
              end
            end
            default: ;
          endcase
          if (tau_r == len_r || walk_end) begin
            state_r <= S_REF;
          end else begin
            // advance to the next lag
            tau_r      <= tau_r + LW'(1);
            rb_start_r <= ring_inc(rb_start_r);
            rb_r       <= ring_inc(rb_start_r);
            ra_r       <= base_r;
            acc_r      <= '0;
            cnt_r      <= '0;
            issue_r    <= 1'b1;
            state_r    <= S_PASS;
          end
        end
        S_REF: begin
          if (srch_r == SR_SEEK) begin
            det_r   <= 1'b0;
            state_r <= S_FIN;
          end else if (!has_np1_r || a_c <= 31'sd0) begin
            per_r   <= base_p;
            state_r <= S_CHK;
          end else begin
            div_rem_r  <= NUMW'({mag_c, 8'b0}) + NUMW'($unsigned(a_c));
            div_den_r  <= SHW'({$unsigned(a_c), 1'b0}) << (QUOT_W - 1);
            div_q_r    <= '0;
            div_cnt_r  <= '0;
            div_norm_r <= 1'b0;
            neg_r      <= nd_c[30];
            state_r    <= S_DIV;
          end
        end
        S_CHK: begin
          det_r   <= (25'(per_r) >= 25'(per_low_r)) && (25'(per_r) <= 25'(per_high_r));
          state_r <= S_FIN;
        end
        S_FIN: begin
          idle_r   <= idle_nxt;
          held_p_r <= held_p_nxt;
          held_c_r <= held_c_nxt;
          out_r.voiced          <= (held_p_nxt != '0);
          out_r.period_q        <= held_p_nxt;
          out_r.confidence_q    <= (held_p_nxt != '0) ? held_c_nxt : 17'd0;
          out_r.level_energy    <= 44'(energy_r);
          state_r               <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign pready    = 1'b1;

  always_comb begin
    unique case (reg_idx_t'(paddr[4:2]))
      REG_LAG_MIN:     prdata = 32'(lag_min_r);
      REG_LAG_MAX:     prdata = 32'(lag_max_r);
      REG_DIP_THRESH:  prdata = 32'(dip_thr_r);
      REG_GATE_LEVEL:  prdata = 32'(gate_r);
      REG_HOLD_TICKS:  prdata = 32'(hold_r);
      REG_PERIOD_LOW:  prdata = 32'(per_low_r);
      REG_PERIOD_HIGH: prdata = 32'(per_high_r);
      REG_UNUSED:      prdata = '0;
    endcase
  end
endmodule

[rtl/ypd_checker.sv]
// Port-level checker of the pitch detector, bound to the top level.
// Depends on ypd_pkg and yin_pitch_detector_unit_defines.svh.
`include "yin_pitch_detector_unit_defines.svh"

module ypd_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input ypd_pkg::in_t  in_data,
  input logic          out_valid,
  input ypd_pkg::out_t out_data
);
  import ypd_pkg::*;

  // pushes never tie up the block
  `YPD_ASSERT_NEXT(a_push_idle, clk, rst_n, start && !busy && in_data.command == CMD_PUSH, !busy)
  // an analyse request holds the block
  `YPD_ASSERT_NEXT(a_ana_busy, clk, rst_n, start && !busy && in_data.command == CMD_ANALYSE, busy)
  // a result only closes an analyse
  `YPD_ASSERT_IMPLY(a_res_after, clk, rst_n, out_valid, $past(busy) && !busy)
  // unvoiced results carry no period or confidence
  `YPD_ASSERT_IMPLY(a_unvoiced, clk, rst_n, out_valid && !out_data.voiced, out_data.period_q == 21'd0 && out_data.confidence_q == 17'd0)
endmodule

bind yin_pitch_detector_unit ypd_checker u_ypd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_data  (out_data)
);
